// ===== sv/tdq_pkg.sv =====
// tdq_pkg: shared types and constants for the ticketed deque
// entry and link structs, cell commands, operation and status codes
// no dependencies
package tdq_pkg;

  localparam int QueueDepth = 16;
  localparam int MaxResults = 16;
  localparam int CountW     = $clog2(QueueDepth + 1);
  localparam int ListLimit  = (MaxResults < QueueDepth) ? MaxResults : QueueDepth;

  typedef enum logic [1:0] {
    OP_INS_BACK  = 2'd0,
    OP_INS_FRONT = 2'd1,
    OP_SERVE     = 2'd2,
    OP_LIST      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_BACK,
    CMD_PUSH_FRONT,
    CMD_POP,
    CMD_ROTATE
  } cell_cmd_e;

  typedef struct packed {
    logic [63:0] name_low;
    logic [63:0] name_high;
    logic [15:0] ticket;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } link_t;

endpackage

// ===== sv/tdq_cell.sv =====
// tdq_cell: one storage cell of the deque chain
// holds one entry and its valid flag, loads a new entry or shifts to or from its neighbours
// depends on tdq_pkg
module tdq_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tdq_pkg::cell_cmd_e   cmd_i,
  input  tdq_pkg::entry_t      new_i,
  input  tdq_pkg::link_t       prev_i,
  input  tdq_pkg::link_t       next_i,
  input  tdq_pkg::entry_t      head_i,
  output tdq_pkg::link_t       cell_o
);
  import tdq_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    unique case (cmd_i)
      CMD_HOLD: ;
      CMD_PUSH_BACK: begin
        if (!valid_q && prev_i.valid) begin
          valid_d = 1'b1;
          entry_d = new_i;
        end
      end
      CMD_PUSH_FRONT: begin
        valid_d = prev_i.valid;
        entry_d = prev_i.entry;
      end
      CMD_POP: begin
        valid_d = next_i.valid;
        entry_d = next_i.entry;
      end
      CMD_ROTATE: begin
        if (valid_q) begin
          entry_d = next_i.valid ? next_i.entry : head_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.entry = entry_q;

endmodule

// ===== sv/ticketed_deque_core.sv =====
// ticketed_deque_core: bounded deque of 16-byte names with ticket stamps
// inserts and serves: one word, registered, in the cycle after accept; busy stays low
// list: busy while in S_LIST, words one a cycle, first registered in out_q after accept enters S_LIST
// list throughput set by the cell chain rotating one place per cycle
// reset clears cell valid flags, count, ticket counter and state; the receiver cannot stall
// depends on tdq_pkg and tdq_cell
module ticketed_deque_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] name_low_i,
  input  logic [63:0] name_high_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] ticket_o,
  output logic [63:0] out_name_low_o,
  output logic [63:0] out_name_high_o,
  output logic        last_o
);
  import tdq_pkg::*;

  typedef enum logic {S_IDLE, S_LIST} state_e;

  state_e              state_q;
  logic [CountW-1:0]   count_q;
  logic [CountW-1:0]   step_q;
  logic [15:0]         tick_q;
  logic                done_q, last_q;
  logic [1:0]          status_q;
  entry_t              out_q;

  link_t               cells [QueueDepth];
  logic [QueueDepth-1:0] valid_vec;
  cell_cmd_e           cmd;
  entry_t              new_entry;
  op_e                 op;
  logic                accept, full, empty;

  assign op        = op_e'(operation_i);
  assign accept    = start_i && (state_q == S_IDLE);
  assign full      = (count_q == CountW'(QueueDepth));
  assign empty     = (count_q == '0);
  assign new_entry = '{name_low: name_low_i, name_high: name_high_i, ticket: tick_q + 16'd1};

  always_comb begin
    cmd = CMD_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_INS_BACK:  cmd = full  ? CMD_HOLD : CMD_PUSH_BACK;
            OP_INS_FRONT: cmd = full  ? CMD_HOLD : CMD_PUSH_FRONT;
            OP_SERVE:     cmd = empty ? CMD_HOLD : CMD_POP;
            OP_LIST:      cmd = CMD_HOLD;
            default:      cmd = CMD_HOLD;
          endcase
        end
      end
      S_LIST:  cmd = CMD_ROTATE;
      default: cmd = CMD_HOLD;
    endcase
  end

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    link_t prev_l, next_l;
    if (i == 0) begin : g_first
      assign prev_l = '{valid: 1'b1, entry: new_entry};
    end else begin : g_mid
      assign prev_l = cells[i-1];
    end
    if (i == QueueDepth - 1) begin : g_end
      assign next_l = '0;
    end else begin : g_inner
      assign next_l = cells[i+1];
    end
    tdq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .new_i  (new_entry),
      .prev_i (prev_l),
      .next_i (next_l),
      .head_i (cells[0].entry),
      .cell_o (cells[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      step_q   <= '0;
      tick_q   <= '0;
      done_q   <= 1'b0;
      last_q   <= 1'b0;
      status_q <= ST_OK;
      out_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_INS_BACK, OP_INS_FRONT: begin
                done_q <= 1'b1;
                last_q <= 1'b1;
                if (full) begin
                  status_q <= ST_FULL;
                  out_q    <= '0;
                end else begin
                  status_q <= ST_OK;
                  out_q    <= new_entry;
                  tick_q   <= new_entry.ticket;
                  count_q  <= count_q + CountW'(1);
                end
              end
              OP_SERVE: begin
                done_q <= 1'b1;
                last_q <= 1'b1;
                if (empty) begin
                  status_q <= ST_EMPTY;
                  out_q    <= '0;
                end else begin
                  status_q <= ST_OK;
                  out_q    <= cells[0].entry;
                  count_q  <= count_q - CountW'(1);
                end
              end
              OP_LIST: begin
                if (empty) begin
                  done_q   <= 1'b1;
                  last_q   <= 1'b1;
                  status_q <= ST_EMPTY;
                  out_q    <= '0;
                end else begin
                  state_q <= S_LIST;
                  step_q  <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_LIST: begin
          if (step_q < CountW'(ListLimit)) begin
            done_q   <= 1'b1;
            status_q <= ST_OK;
            out_q    <= cells[0].entry;
            last_q   <= (step_q == count_q - CountW'(1)) ||
                        (step_q == CountW'(ListLimit - 1));
          end
          step_q <= step_q + CountW'(1);
          if (step_q == count_q - CountW'(1)) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o          = (state_q == S_LIST);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign ticket_o        = out_q.ticket;
  assign out_name_low_o  = out_q.name_low;
  assign out_name_high_o = out_q.name_high;
  assign last_o          = last_q;

`ifndef NO_ASSERTIONS
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("entry count disagrees with occupied cells");

  a_list_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> (count_q != '0))
    else $error("listing with an empty deque");

  a_insert_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_INS_BACK || op == OP_INS_FRONT) && !full)
      |=> (done_o && last_o && status_o == ST_OK && ticket_o == tick_q))
    else $error("accepted insert gave no ok word with its ticket");
`endif

endmodule
